// ----- hw/rtl/apem_pkg.sv -----
// Shared constants and types for the peak envelope meter.
package apem_pkg;

    // Samples per metering window.
    localparam int WINDOW_SAMPLES = 64;
    localparam int COUNT_W = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
    localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(WINDOW_SAMPLES - 1);

    // Field widths.
    localparam int SAMPLE_W = 16;
    localparam int PACKED_W = 2 * SAMPLE_W;
    localparam int LEVEL_W  = 7;

    // Level mapping: (peak - FLOOR) * 100 / 6200, clamped to 100.
    localparam logic [SAMPLE_W-1:0] FLOOR_LEVEL = 16'd280;
    localparam logic [SAMPLE_W-1:0] LEVEL_SPAN  = 16'd6200;
    localparam logic [LEVEL_W-1:0]  LEVEL_MAX   = 7'd100;

    // Below the clamp, x*100/6200 == x/62; x < 8192 so x/62 == (x*8457) >> 19.
    localparam int DIFF_W      = 13;
    localparam int RECIP_W     = 14;
    localparam int RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP_MULT = 14'd8457;
    localparam int PROD_W = DIFF_W + RECIP_W;

    typedef logic [SAMPLE_W-1:0] peak_t;
    typedef logic [LEVEL_W-1:0]  level_t;
    typedef logic [COUNT_W-1:0]  count_t;

endpackage

// ----- hw/rtl/apem_sample_if.sv -----
// Input channel: one packed stereo sample per beat.
interface apem_sample_if;
    logic                             valid;
    logic                             ready;
    logic [apem_pkg::PACKED_W-1:0]    packed_sample;

    modport source (output valid, output packed_sample, input ready);
    modport sink   (input valid, input packed_sample, output ready);
endinterface

// ----- hw/rtl/apem_level_if.sv -----
// Output channel: current level and publication flag per beat.
interface apem_level_if;
    logic                 valid;
    logic                 ready;
    apem_pkg::level_t     level;
    logic                 published;

    modport source (output valid, output level, output published, input ready);
    modport sink   (input valid, input level, input published, output ready);
endinterface

// ----- hw/rtl/apem_cfg_if.sv -----
// Configuration write channel: the enable register.
interface apem_cfg_if;
    logic valid;
    logic ready;
    logic enabled;

    modport source (output valid, output enabled, input ready);
    modport sink   (input valid, input enabled, output ready);
endinterface

// ----- hw/rtl/apem_peak_detect.sv -----
// Stereo magnitude and larger-channel select for one packed sample.
module apem_peak_detect (
    input  logic [apem_pkg::PACKED_W-1:0] packed_sample,
    output apem_pkg::peak_t               peak
);

    apem_pkg::peak_t left_raw;
    apem_pkg::peak_t right_raw;
    apem_pkg::peak_t left_mag;
    apem_pkg::peak_t right_mag;

    assign left_raw  = packed_sample[apem_pkg::SAMPLE_W-1:0];
    assign right_raw = packed_sample[apem_pkg::PACKED_W-1:apem_pkg::SAMPLE_W];

    // Two's complement negate; the most negative code wraps to 0x8000 = 32768.
    assign left_mag  = left_raw[apem_pkg::SAMPLE_W-1]  ? (~left_raw + 1'b1)  : left_raw;
    assign right_mag = right_raw[apem_pkg::SAMPLE_W-1] ? (~right_raw + 1'b1) : right_raw;

    assign peak = (right_mag > left_mag) ? right_mag : left_mag;

endmodule

// ----- hw/rtl/apem_level_map.sv -----
// Window peak to target level, then one attack/release envelope step.
module apem_level_map (
    input  apem_pkg::peak_t  peak,
    input  apem_pkg::level_t envelope,
    output apem_pkg::level_t envelope_new
);

    apem_pkg::peak_t                   diff;
    logic [apem_pkg::PROD_W-1:0]       prod;
    apem_pkg::level_t                  target;
    logic [apem_pkg::LEVEL_W+1:0]      attack_sum;
    logic [apem_pkg::LEVEL_W+2:0]      release_sum;

    // Part of the peak above the floor.
    assign diff = (peak > apem_pkg::FLOOR_LEVEL) ? (peak - apem_pkg::FLOOR_LEVEL) : '0;

    // Divide by 62 via reciprocal multiply; valid while diff < span.
    assign prod = apem_pkg::PROD_W'(diff[apem_pkg::DIFF_W-1:0]) *
                  apem_pkg::PROD_W'(apem_pkg::RECIP_MULT);

    // Clamp at full scale.
    always_comb
    begin
        if (diff >= apem_pkg::LEVEL_SPAN)
        begin
            target = apem_pkg::LEVEL_MAX;
        end
        else
        begin
            target = prod[apem_pkg::RECIP_SHIFT +: apem_pkg::LEVEL_W];
        end
    end

    // Attack: (env + 3t)/4. Release: (7env + t)/8.
    assign attack_sum  = {2'b00, envelope} + {1'b0, target, 1'b0} + {2'b00, target};
    assign release_sum = {envelope, 3'b000} - {3'b000, envelope} + {3'b000, target};

    always_comb
    begin
        if (target >= envelope)
        begin
            envelope_new = attack_sum[apem_pkg::LEVEL_W+1:2];
        end
        else
        begin
            envelope_new = release_sum[apem_pkg::LEVEL_W+2:3];
        end
    end

endmodule

// ----- hw/rtl/audio_peak_envelope_meter_core.sv -----
// Top level of the stereo peak envelope meter.
// Structure: input register, then one pass of logic into the result register,
// with window peak, count and envelope held beside it. Throughput: one sample
// per cycle while levels.ready does not hold the result register.
// Reset: enabled = 1, envelope, window peak and sample count cleared, pipeline empty.
// Writing enabled = 0 clears envelope, window peak and count at once.
module audio_peak_envelope_meter_core (
    input  logic               clk,
    input  logic               rst_n,
    apem_sample_if.sink        samples,
    apem_level_if.source       levels,
    apem_cfg_if.sink           cfg
);

    // Input stage
    logic                          in_valid_reg;
    logic [apem_pkg::PACKED_W-1:0] sample_reg;

    // Meter state
    logic                          en_reg;
    apem_pkg::level_t              envelope_reg;
    apem_pkg::level_t              envelope_next;
    apem_pkg::peak_t               window_peak_reg;
    apem_pkg::peak_t               window_peak_next;
    apem_pkg::count_t              count_reg;
    apem_pkg::count_t              count_next;

    // Result stage
    logic                          out_valid_reg;
    apem_pkg::level_t              level_reg;
    logic                          published_reg;
    logic                          fresh;

    logic                          out_free;
    logic                          s1_fire;
    logic                          in_fire;
    logic                          cfg_fire;

    apem_pkg::peak_t               sample_peak;
    apem_pkg::peak_t               merged_peak;
    apem_pkg::level_t              envelope_step;

    // Handshake
    assign out_free      = !out_valid_reg || levels.ready;
    assign s1_fire       = in_valid_reg && out_free;
    assign samples.ready = !in_valid_reg || out_free;
    assign in_fire       = samples.valid && samples.ready;
    assign cfg.ready     = 1'b1;
    assign cfg_fire      = cfg.valid;

    assign levels.valid     = out_valid_reg;
    assign levels.level     = level_reg;
    assign levels.published = published_reg;

    // Datapath
    apem_peak_detect u_peak (
        .packed_sample (sample_reg),
        .peak          (sample_peak)
    );

    assign merged_peak = (sample_peak > window_peak_reg) ? sample_peak : window_peak_reg;

    apem_level_map u_map (
        .peak         (merged_peak),
        .envelope     (envelope_reg),
        .envelope_new (envelope_step)
    );

    // Window accumulate and publish
    always_comb
    begin
        envelope_next    = envelope_reg;
        window_peak_next = window_peak_reg;
        count_next       = count_reg;
        fresh            = 1'b0;
        if (en_reg)
        begin
            if (count_reg == apem_pkg::LAST_COUNT)
            begin
                envelope_next    = envelope_step;
                window_peak_next = '0;
                count_next       = '0;
                fresh            = 1'b1;
            end
            else
            begin
                window_peak_next = merged_peak;
                count_next       = count_reg + 1'b1;
            end
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            en_reg          <= 1'b1;
            envelope_reg    <= '0;
            window_peak_reg <= '0;
            count_reg       <= '0;
        end
        else
        begin
            if (samples.ready)
            begin
                in_valid_reg <= samples.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (cfg_fire && (cfg.enabled != en_reg))
            begin
                en_reg <= cfg.enabled;
                if (!cfg.enabled)
                begin
                    envelope_reg    <= '0;
                    window_peak_reg <= '0;
                    count_reg       <= '0;
                end
            end
            else if (s1_fire)
            begin
                envelope_reg    <= envelope_next;
                window_peak_reg <= window_peak_next;
                count_reg       <= count_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sample_reg <= samples.packed_sample;
        end
        if (s1_fire)
        begin
            level_reg     <= envelope_next;
            published_reg <= fresh;
        end
    end

endmodule
